// ----- src/olpu_pkg.sv -----
// olpu_pkg: shared types and constants for the ordered list update unit
// no dependencies; imported by every module under src

package olpu_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int LENOUT_W = 5;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT = 3'd0,
    K_INS_BACK  = 3'd1,
    K_DEL_FRONT = 3'd2,
    K_DEL_BACK  = 3'd3,
    K_INS_AT    = 3'd4,
    K_DEL_AT    = 3'd5
  } olpu_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } olpu_status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } olpu_op_t;

  typedef enum logic {
    S_WAIT_IN  = 1'b0,
    S_HOLD_OUT = 1'b1
  } olpu_state_t;

  typedef struct packed {
    olpu_op_t op;
  } olpu_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } olpu_flags_t;

endpackage

// ----- src/ordered_list_positional_update_unit.sv -----
// channel | tvalid/tready        | tuser        | tdata
// in_     | transaction accepted | kind[2:0]    | value[31:0] position[36:32]
// out_    | transaction accepted | -            | status[1:0] length_after[6:2]
//
// the whole cell row shifts in the accept cycle
// the result is registered and shows on the cycle after acceptance
// a new item is taken in the same cycle that the held result is taken
// synchronous active-low reset empties the list; cell contents are not cleared
// top level of the ordered list update unit; depends on olpu_pkg, olpu_ctrl, olpu_dpath

module ordered_list_positional_update_unit #(
  parameter int CAPACITY = olpu_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], position[36:32], zero[39:37]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[1:0], length_after[6:2], zero[7]
);
  import olpu_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

  olpu_cmd_t     cmd;
  olpu_flags_t   flags;
  olpu_status_t  status;
  logic [CW-1:0] idx;
  logic [CW-1:0] len;

  olpu_ctrl #(
    .CW (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .kind      (in_tuser),
    .position  (in_tdata[36:32]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .flags     (flags),
    .len       (len),
    .cmd       (cmd),
    .idx       (idx)
  );

  olpu_dpath #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_dpath (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .idx   (idx),
    .value (in_tdata[31:0]),
    .flags (flags),
    .len   (len)
  );

  assign out_tdata = {1'b0, len[LENOUT_W-1:0], status};

endmodule

// ----- src/olpu_dpath.sv -----
// olpu_dpath: row of element cells, list length and insert/delete shifting
// depends on olpu_pkg; driven by olpu_ctrl commands

module olpu_dpath #(
  parameter int CAPACITY = olpu_pkg::CAPACITY_DEF,
  parameter int CW       = (($clog2(CAPACITY + 1) > olpu_pkg::POS_W) ?
                            $clog2(CAPACITY + 1) : olpu_pkg::POS_W) + 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  olpu_pkg::olpu_cmd_t          cmd,
  input  logic [CW-1:0]                idx,
  input  logic [olpu_pkg::VALUE_W-1:0] value,
  output olpu_pkg::olpu_flags_t        flags,
  output logic [CW-1:0]                len
);
  import olpu_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);

  logic [VALUE_W-1:0] cell_r   [CAPACITY];
  logic [VALUE_W-1:0] cell_nxt [CAPACITY];
  logic [LW-1:0]      len_r, len_nxt;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    always_comb begin
      cell_nxt[i] = cell_r[i];
      case (cmd.op)
        OP_INS: begin
          if (CW'(i) == idx) begin
            cell_nxt[i] = value;
          end else if (CW'(i) > idx) begin
            if (i > 0) begin
              cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
            end
          end
        end
        OP_DEL: begin
          if (CW'(i) >= idx) begin
            if (i < CAPACITY - 1) begin
              cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
            end
          end
        end
        default: begin
          cell_nxt[i] = cell_r[i];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_comb begin
    case (cmd.op)
      OP_INS:  len_nxt = len_r + LW'(1);
      OP_DEL:  len_nxt = len_r - LW'(1);
      default: len_nxt = len_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign len         = CW'(len_r);
  assign flags.full  = (len_r == LW'(CAPACITY));
  assign flags.empty = (len_r == '0);

endmodule

// ----- src/olpu_ctrl.sv -----
// olpu_ctrl: handshake state machine, operation decode and result status
// depends on olpu_pkg; commands olpu_dpath

module olpu_ctrl #(
  parameter int CW = olpu_pkg::POS_W + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [olpu_pkg::KIND_W-1:0]   kind,
  input  logic [olpu_pkg::POS_W-1:0]    position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output olpu_pkg::olpu_status_t        status,
  input  olpu_pkg::olpu_flags_t         flags,
  input  logic [CW-1:0]                 len,
  output olpu_pkg::olpu_cmd_t           cmd,
  output logic [CW-1:0]                 idx
);
  import olpu_pkg::*;

  olpu_state_t  state_r, state_nxt;
  olpu_status_t status_r, status_nxt;
  olpu_op_t     op_dec;
  logic         accept;
  logic [CW-1:0] pos_x;

  assign pos_x    = CW'(position);
  assign in_ready = (state_r == S_WAIT_IN) || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    op_dec     = OP_NONE;
    idx        = '0;
    status_nxt = ST_DONE;
    case (kind)
      K_INS_FRONT: begin
        if (flags.full) status_nxt = ST_FULL;
        else op_dec = OP_INS;
      end
      K_INS_BACK: begin
        idx = len;
        if (flags.full) status_nxt = ST_FULL;
        else op_dec = OP_INS;
      end
      K_DEL_FRONT: begin
        if (flags.empty) status_nxt = ST_EMPTY;
        else op_dec = OP_DEL;
      end
      K_DEL_BACK: begin
        idx = len - CW'(1);
        if (flags.empty) status_nxt = ST_EMPTY;
        else op_dec = OP_DEL;
      end
      K_INS_AT: begin
        idx = pos_x - CW'(1);
        if (pos_x == '0 || pos_x > len + CW'(1)) status_nxt = ST_BADPOS;
        else if (flags.full) status_nxt = ST_FULL;
        else op_dec = OP_INS;
      end
      K_DEL_AT: begin
        idx = pos_x - CW'(1);
        if (pos_x == '0 || pos_x > len) status_nxt = ST_BADPOS;
        else op_dec = OP_DEL;
      end
      default: begin
        status_nxt = ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = accept ? op_dec : OP_NONE;
    case (state_r)
      S_WAIT_IN: begin
        if (accept) state_nxt = S_HOLD_OUT;
      end
      S_HOLD_OUT: begin
        if (out_ready && !accept) state_nxt = S_WAIT_IN;
      end
      default: begin
        state_nxt = S_WAIT_IN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WAIT_IN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid = (state_r == S_HOLD_OUT);
  assign status    = status_r;

endmodule

// ----- src/olpu_checker.sv -----
// olpu_checker: port-level checks on the ordered list update unit
// depends on olpu_pkg; bound to ordered_list_positional_update_unit below

module olpu_checker #(
  parameter int CAPACITY = olpu_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  import olpu_pkg::*;

  localparam logic [LENOUT_W-1:0] CAP_LEN = LENOUT_W'(CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("held result changed");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted transaction");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_FULL |-> out_tdata[6:2] == CAP_LEN)
    else $error("full status with wrong length");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == ST_EMPTY |-> out_tdata[6:2] == '0)
    else $error("empty status with nonzero length");

endmodule

bind ordered_list_positional_update_unit olpu_checker #(
  .CAPACITY (CAPACITY)
) u_olpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
